// File: rtl/jgsc_pkg.sv
// Shared types and constants for the joystick gesture step command block.
// Holds register indexes, reset values and the configuration struct.
// No dependencies.
`default_nettype none

package jgsc_pkg;

	localparam int unsigned RegWidth   = 15;
	localparam int unsigned AxisWidth  = 16;
	localparam int unsigned CmdWidth   = 16;
	localparam int unsigned IndexWidth = 3;

	// Register reset values (levels are 0.45 and 0.20 in Q2.14)
	localparam logic [RegWidth-1:0] StepSizeReset     = 15'd500;
	localparam logic [RegWidth-1:0] PitchLimitReset   = 15'd3000;
	localparam logic [RegWidth-1:0] RollLimitReset    = 15'd3000;
	localparam logic [RegWidth-1:0] TriggerLevelReset = 15'd7373;
	localparam logic [RegWidth-1:0] ReleaseLevelReset = 15'd3277;

	typedef enum logic [IndexWidth-1:0] {
		REG_STEP_SIZE     = 3'd0,
		REG_PITCH_LIMIT   = 3'd1,
		REG_ROLL_LIMIT    = 3'd2,
		REG_TRIGGER_LEVEL = 3'd3,
		REG_RELEASE_LEVEL = 3'd4
	} reg_index_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_RESET  = 1'b1
	} opcode_t;

	// Settings shared by both axis units
	typedef struct packed {
		logic [RegWidth-1:0] step_size;
		logic [RegWidth-1:0] trigger_level;
		logic [RegWidth-1:0] release_level;
	} axis_cfg_t;

	// Per-axis state that the unit reads and rewrites each item
	typedef struct packed {
		logic                       armed;
		logic signed [CmdWidth-1:0] value;
	} axis_state_t;

endpackage

`default_nettype wire

// File: rtl/jgsc_axis.sv
// One axis of the gesture step command block: arming hysteresis, step and clamp.
// Pure combinational; depends on jgsc_pkg.
`default_nettype none

module jgsc_axis (
	input  wire logic                               is_reset,
	input  wire logic                               invert,
	input  wire logic signed [jgsc_pkg::AxisWidth-1:0] axis,
	input  wire logic        [jgsc_pkg::RegWidth-1:0]  limit,
	input  wire jgsc_pkg::axis_cfg_t                cfg,
	input  wire jgsc_pkg::axis_state_t              cur,
	output jgsc_pkg::axis_state_t                   nxt,
	output logic                                    changed
);
	import jgsc_pkg::*;

	localparam int unsigned SumWidth = CmdWidth + 2;

	logic [AxisWidth-1:0]       mag;
	logic                       below_release;
	logic                       at_trigger;
	logic                       fire;
	logic                       positive;
	logic                       step_up;
	logic signed [SumWidth-1:0] prev_ext;
	logic signed [SumWidth-1:0] step_ext;
	logic signed [SumWidth-1:0] lim_ext;
	logic signed [SumWidth-1:0] sum;
	logic signed [SumWidth-1:0] clamped;

	// Magnitude; full-scale negative maps to 32768
	assign mag           = axis[AxisWidth-1] ? (~axis + 1'b1) : axis;
	assign below_release = mag <= {1'b0, cfg.release_level};
	assign at_trigger    = mag >= {1'b0, cfg.trigger_level};
	assign fire          = cur.armed && at_trigger;
	assign positive      = !axis[AxisWidth-1] && (axis != '0);
	assign step_up       = invert ? !positive : positive;

	// Add or subtract one step, then clamp to the symmetric limit
	assign prev_ext = SumWidth'(cur.value);
	assign step_ext = SumWidth'({1'b0, cfg.step_size});
	assign lim_ext  = SumWidth'({1'b0, limit});
	assign sum      = step_up ? (prev_ext + step_ext) : (prev_ext - step_ext);

	always_comb begin
		if (sum > lim_ext) begin
			clamped = lim_ext;
		end else if (sum < -lim_ext) begin
			clamped = -lim_ext;
		end else begin
			clamped = sum;
		end
	end

	// Select the next state and change flag
	always_comb begin
		nxt     = cur;
		changed = 1'b0;
		if (is_reset) begin
			nxt.value = '0;
			nxt.armed = below_release;
			changed   = cur.value != '0;
		end else if (!cur.armed) begin
			nxt.armed = below_release;
		end else if (fire) begin
			nxt.armed = 1'b0;
			nxt.value = clamped[CmdWidth-1:0];
			changed   = clamped != prev_ext;
		end
	end

endmodule

`default_nettype wire

// File: rtl/joystick_gesture_step_command.sv
// Top level of the joystick gesture step command block.
// Input register, two axis units, result register; depends on jgsc_pkg and jgsc_axis.
`default_nettype none

// Each accepted item (joystick sample or reset command) yields exactly one result.
// An item is held in the input register, then both axis units update the
// pitch and roll commands and arming flags in a single pass into the result
// register. One item per clock is sustained while out_ready does not stall the
// result register; the result is valid once the item has passed the input and
// result registers, and stays until out_ready takes it. Commands and arming flags
// feed back from the result register into the axis units, and that loop sets the
// one-item-per-cycle figure. Configuration registers take effect on the next item.
module joystick_gesture_step_command (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [jgsc_pkg::IndexWidth-1:0]      cfg_index,
	input  wire logic [jgsc_pkg::RegWidth-1:0]        cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 opcode,
	input  wire logic signed [jgsc_pkg::AxisWidth-1:0] axis_x,
	input  wire logic signed [jgsc_pkg::AxisWidth-1:0] axis_y,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic                                      pitch_changed,
	output logic                                      roll_changed,
	output logic                                      was_reset,
	output logic signed [jgsc_pkg::CmdWidth-1:0]      pitch_command,
	output logic signed [jgsc_pkg::CmdWidth-1:0]      roll_command
);
	import jgsc_pkg::*;

	logic [RegWidth-1:0] step_size_q;
	logic [RegWidth-1:0] pitch_limit_q;
	logic [RegWidth-1:0] roll_limit_q;
	logic [RegWidth-1:0] trigger_level_q;
	logic [RegWidth-1:0] release_level_q;

	logic                        valid_s1;
	logic                        opcode_s1;
	logic signed [AxisWidth-1:0] axis_x_s1;
	logic signed [AxisWidth-1:0] axis_y_s1;

	logic out_valid_q;
	logic pitch_changed_q;
	logic roll_changed_q;
	logic was_reset_q;

	axis_state_t pitch_q;
	axis_state_t roll_q;
	axis_state_t pitch_nxt;
	axis_state_t roll_nxt;
	logic        pitch_chg;
	logic        roll_chg;
	logic        is_reset;
	logic        advance;
	axis_cfg_t   cfg;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q     <= StepSizeReset;
			pitch_limit_q   <= PitchLimitReset;
			roll_limit_q    <= RollLimitReset;
			trigger_level_q <= TriggerLevelReset;
			release_level_q <= ReleaseLevelReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_SIZE:     step_size_q     <= cfg_data;
				REG_PITCH_LIMIT:   pitch_limit_q   <= cfg_data;
				REG_ROLL_LIMIT:    roll_limit_q    <= cfg_data;
				REG_TRIGGER_LEVEL: trigger_level_q <= cfg_data;
				REG_RELEASE_LEVEL: release_level_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = '{step_size: step_size_q, trigger_level: trigger_level_q,
		release_level: release_level_q};

	// Handshake: advance the input stage when the result slot is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			axis_x_s1 <= axis_x;
			axis_y_s1 <= axis_y;
		end
	end

	assign is_reset = opcode_s1 == OP_RESET;

	// Pitch follows the X sign
	jgsc_axis u_pitch (
		.is_reset (is_reset),
		.invert   (1'b0),
		.axis     (axis_x_s1),
		.limit    (pitch_limit_q),
		.cfg      (cfg),
		.cur      (pitch_q),
		.nxt      (pitch_nxt),
		.changed  (pitch_chg)
	);

	// Roll follows the inverted Y sign
	jgsc_axis u_roll (
		.is_reset (is_reset),
		.invert   (1'b1),
		.axis     (axis_y_s1),
		.limit    (roll_limit_q),
		.cfg      (cfg),
		.cur      (roll_q),
		.nxt      (roll_nxt),
		.changed  (roll_chg)
	);

	// Result register and axis state; state only moves with a new result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q     <= 1'b0;
			pitch_q         <= '0;
			roll_q          <= '0;
			pitch_changed_q <= 1'b0;
			roll_changed_q  <= 1'b0;
			was_reset_q     <= 1'b0;
		end else if (advance) begin
			out_valid_q     <= 1'b1;
			pitch_q         <= pitch_nxt;
			roll_q          <= roll_nxt;
			pitch_changed_q <= pitch_chg;
			roll_changed_q  <= roll_chg;
			was_reset_q     <= is_reset;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign pitch_changed = pitch_changed_q;
	assign roll_changed  = roll_changed_q;
	assign was_reset     = was_reset_q;
	assign pitch_command = pitch_q.value;
	assign roll_command  = roll_q.value;

endmodule

`default_nettype wire
